// ----- sv/oled_controller_byte_interface_top_defines.svh -----
// Assertion macros for the OLED byte interface.
`ifndef OLED_CONTROLLER_BYTE_INTERFACE_TOP_DEFINES_SVH
`define OLED_CONTROLLER_BYTE_INTERFACE_TOP_DEFINES_SVH

// Same-cycle implication, checked once reset has been released.
`define OLBI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olbi same-cycle check failed");

// Next-cycle implication, checked once reset has been released.
`define OLBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olbi next-cycle check failed");

`endif

// ----- sv/olbi_pkg.sv -----
package olbi_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int ROW_BYTES   = 128;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int ROW_SHIFT   = $clog2(ROW_BYTES);
    localparam int CLR_W       = ADDR_W + 1;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // word codes on the input channel
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // control bytes seen while idle
    localparam logic [7:0] CTRL_CMD  = 8'h80;
    localparam logic [7:0] CTRL_DATA = 8'h40;

    // controller command bytes
    localparam logic [7:0] OP_COL_LO_FIRST = 8'h00;
    localparam logic [7:0] OP_COL_LO_LAST  = 8'h0f;
    localparam logic [7:0] OP_COL_HI_FIRST = 8'h10;
    localparam logic [7:0] OP_COL_HI_LAST  = 8'h1f;
    localparam logic [7:0] OP_ADDR_MODE    = 8'h20;
    localparam logic [7:0] OP_COL_WIN      = 8'h21;
    localparam logic [7:0] OP_PAGE_WIN     = 8'h22;
    localparam logic [7:0] OP_CONTRAST     = 8'h81;
    localparam logic [7:0] OP_FLASH_OFF    = 8'ha4;
    localparam logic [7:0] OP_FLASH_ON     = 8'ha5;
    localparam logic [7:0] OP_INV_OFF      = 8'ha6;
    localparam logic [7:0] OP_INV_ON       = 8'ha7;
    localparam logic [7:0] OP_MUX_RATIO    = 8'ha8;
    localparam logic [7:0] OP_DCDC         = 8'had;
    localparam logic [7:0] OP_DISP_OFF     = 8'hae;
    localparam logic [7:0] OP_DISP_ON      = 8'haf;
    localparam logic [7:0] OP_PAGE_FIRST   = 8'hb0;
    localparam logic [7:0] OP_PAGE_LAST    = 8'hbf;
    localparam logic [7:0] OP_OFFSET       = 8'hd3;
    localparam logic [7:0] OP_CLK_DIV      = 8'hd5;
    localparam logic [7:0] OP_COLOR        = 8'hd8;
    localparam logic [7:0] OP_PRECHARGE    = 8'hd9;
    localparam logic [7:0] OP_COM_PINS     = 8'hda;
    localparam logic [7:0] OP_VCOMH        = 8'hdb;

    localparam logic [7:0] COL_HI_RESET  = 8'd127;
    localparam logic [7:0] PAGE_HI_RESET = 8'd7;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DATA = 2'd1,
        MODE_CMD  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ARG_NONE       = 3'd0,
        ARG_SKIP       = 3'd1,
        ARG_COL_START  = 3'd2,
        ARG_COL_END    = 3'd3,
        ARG_PAGE_START = 3'd4,
        ARG_PAGE_END   = 3'd5
    } arg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_value;
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic pixel_on;
        logic display_enabled;
    } out_item_t;

    // one memory operation handed from front to back
    typedef struct packed {
        logic              is_read;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        logic [2:0]        bit_sel;
        logic              flash;
        logic              invert;
        logic              enable;
    } mem_op_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ----- sv/oled_controller_byte_interface_top.sv -----
// Read path: an accepted pixel read word goes through the op queue, the read
//   register and the output register, and waits behind older ops still queued.
// Throughput: one word per cycle while in_stall is low; the front classifies
//   and updates all control state per word, the back does one memory write or
//   one read per cycle unless a read waits on the output stage. Reset: asynchronous,
//   active low; then a clearing pass zeroes the store, one byte per cycle, in_stall high.
`include "oled_controller_byte_interface_top_defines.svh"

module oled_controller_byte_interface_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  olbi_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output olbi_pkg::out_item_t out_item
);
    import olbi_pkg::*;

    // Structure
    //   front : owns bus mode, pending argument, column/page pointer, windows
    //           and display flags. Each accepted word updates them at once and,
    //           for a stored data byte or a pixel read, emits one memory op.
    //           Flags are captured into the read op so the result reflects the
    //           state at the time the read word was taken.
    //   queue : short FIFO of memory ops; keeps writes and reads in order, so a
    //           read always sees every earlier data byte.
    //   back  : pixel store (one write port, one registered read port), the
    //           post-reset clearing sweep, and the output register.

    logic         accept;
    logic         push;
    mem_op_t      push_op;
    logic         pop;
    mem_op_t      head;
    q_status_t    q_status;
    back_status_t back_status;

    // stall while the store is being cleared or the op queue has no room
    assign in_stall = back_status.clearing || q_status.full;
    assign accept   = in_valid && !in_stall;

    olbi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .push   (push),
        .op     (push_op)
    );

    olbi_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    olbi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .status    (back_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // no op may be pushed into a full queue
    `OLBI_ASSERT_NOW(a_no_overflow, clk, rst_n, q_status.full, !push)
    // while the store is swept nothing is queued and no result is shown
    `OLBI_ASSERT_NOW(a_clear_quiet, clk, rst_n, back_status.clearing,
                     !q_status.not_empty && !out_valid)
    // an accepted pixel read is sitting in the queue on the next cycle
    `OLBI_ASSERT_NEXT(a_read_queued, clk, rst_n, accept && in_item.cmd == CMD_READ,
                      q_status.not_empty)

endmodule

// ----- sv/olbi_front.sv -----
module olbi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  olbi_pkg::in_item_t item,
    output logic               push,
    output olbi_pkg::mem_op_t  op
);
    import olbi_pkg::*;

    mode_t      bus_mode_reg, bus_mode_next;
    arg_t       arg_reg, arg_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] page_reg, page_next;
    logic [7:0] col_lo_reg, col_lo_next;
    logic [7:0] col_hi_reg, col_hi_next;
    logic [7:0] page_hi_reg, page_hi_next;
    logic       flash_reg, flash_next;
    logic       invert_reg, invert_next;
    logic       enable_reg, enable_next;

    logic [15:0] ptr_addr;
    logic        addr_ok;
    logic [8:0]  col_inc;
    logic [8:0]  page_inc;
    logic [7:0]  b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg <= MODE_IDLE;
            arg_reg      <= ARG_NONE;
            col_reg      <= '0;
            page_reg     <= '0;
            col_lo_reg   <= '0;
            col_hi_reg   <= COL_HI_RESET;
            page_hi_reg  <= PAGE_HI_RESET;
            flash_reg    <= 1'b0;
            invert_reg   <= 1'b0;
            enable_reg   <= 1'b0;
        end
        else
        begin
            bus_mode_reg <= bus_mode_next;
            arg_reg      <= arg_next;
            col_reg      <= col_next;
            page_reg     <= page_next;
            col_lo_reg   <= col_lo_next;
            col_hi_reg   <= col_hi_next;
            page_hi_reg  <= page_hi_next;
            flash_reg    <= flash_next;
            invert_reg   <= invert_next;
            enable_reg   <= enable_next;
        end
    end

    // pointer address uses full 8-bit page and column
    assign ptr_addr = (16'(page_reg) << ROW_SHIFT) + 16'(col_reg);
    assign addr_ok  = (ptr_addr < 16'(STORE_BYTES));
    assign b        = item.byte_value;

    always_comb
    begin
        bus_mode_next = bus_mode_reg;
        arg_next      = arg_reg;
        col_next      = col_reg;
        page_next     = page_reg;
        col_lo_next   = col_lo_reg;
        col_hi_next   = col_hi_reg;
        page_hi_next  = page_hi_reg;
        flash_next    = flash_reg;
        invert_next   = invert_reg;
        enable_next   = enable_reg;
        push          = 1'b0;
        op            = '0;
        col_inc       = 9'(col_reg) + 9'd1;
        page_inc      = 9'(page_reg);

        op.flash  = flash_reg;
        op.invert = invert_reg;
        op.enable = enable_reg;

        if (accept)
        begin
            case (item.cmd)
                CMD_BYTE:
                begin
                    case (bus_mode_reg)
                        MODE_DATA:
                        begin
                            push     = addr_ok;
                            op.addr  = ptr_addr[ADDR_W-1:0];
                            op.wdata = b;
                            // advance within the column window, wrap page
                            if (col_inc > 9'(col_hi_reg))
                            begin
                                page_inc = 9'(page_reg) + 9'd1;
                                col_inc  = 9'(col_lo_reg);
                            end
                            if (page_inc > 9'(page_hi_reg))
                            begin
                                page_inc = '0;
                            end
                            col_next  = col_inc[7:0];
                            page_next = page_inc[7:0];
                        end
                        MODE_CMD:
                        begin
                            arg_next = ARG_NONE;
                            case (arg_reg)
                                ARG_COL_START:
                                begin
                                    arg_next    = ARG_COL_END;
                                    col_lo_next = b;
                                    col_next    = b;
                                end
                                ARG_COL_END:    col_hi_next = b;
                                ARG_PAGE_START:
                                begin
                                    arg_next  = ARG_PAGE_END;
                                    page_next = b;
                                end
                                ARG_PAGE_END:   page_hi_next = b;
                                ARG_SKIP:       ;
                                default:
                                begin
                                    // plain command: back to idle
                                    bus_mode_next = MODE_IDLE;
                                    if (b inside {[OP_COL_LO_FIRST:OP_COL_LO_LAST]})
                                    begin
                                        col_next = {col_reg[7:4], b[3:0]};
                                    end
                                    else if (b inside {[OP_COL_HI_FIRST:OP_COL_HI_LAST]})
                                    begin
                                        col_next = {b[3:0], col_reg[3:0]};
                                    end
                                    else if (b inside {[OP_PAGE_FIRST:OP_PAGE_LAST]})
                                    begin
                                        page_next = {5'd0, b[2:0]};
                                    end
                                    else
                                    begin
                                        case (b)
                                            OP_ADDR_MODE, OP_CONTRAST, OP_MUX_RATIO,
                                            OP_DCDC, OP_OFFSET, OP_CLK_DIV, OP_COLOR,
                                            OP_PRECHARGE, OP_COM_PINS, OP_VCOMH:
                                                arg_next = ARG_SKIP;
                                            OP_COL_WIN:   arg_next = ARG_COL_START;
                                            OP_PAGE_WIN:  arg_next = ARG_PAGE_START;
                                            OP_FLASH_OFF: flash_next = 1'b0;
                                            OP_FLASH_ON:  flash_next = 1'b1;
                                            OP_INV_OFF:   invert_next = 1'b0;
                                            OP_INV_ON:    invert_next = 1'b1;
                                            OP_DISP_OFF:  enable_next = 1'b0;
                                            OP_DISP_ON:   enable_next = 1'b1;
                                            default:      ;
                                        endcase
                                    end
                                end
                            endcase
                        end
                        default:
                        begin
                            if (b == CTRL_CMD)
                            begin
                                bus_mode_next = MODE_CMD;
                            end
                            else if (b == CTRL_DATA)
                            begin
                                bus_mode_next = MODE_DATA;
                            end
                        end
                    endcase
                end
                CMD_END:
                begin
                    bus_mode_next = MODE_IDLE;
                end
                CMD_READ:
                begin
                    push       = 1'b1;
                    op.is_read = 1'b1;
                    op.addr    = ADDR_W'({item.pixel_y[5:3], item.pixel_x});
                    op.bit_sel = item.pixel_y[2:0];
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/olbi_queue.sv -----
module olbi_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  olbi_pkg::mem_op_t   push_op,
    input  logic                pop,
    output olbi_pkg::mem_op_t   head,
    output olbi_pkg::q_status_t status
);
    import olbi_pkg::*;

    mem_op_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QCNT_W'(QDEPTH));

endmodule

// ----- sv/olbi_back.sv -----
module olbi_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  olbi_pkg::mem_op_t      head,
    input  olbi_pkg::q_status_t    q_status,
    output logic                   pop,
    output olbi_pkg::back_status_t status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output olbi_pkg::out_item_t    out_item
);
    import olbi_pkg::*;

    logic [7:0]         mem [STORE_BYTES];
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               clearing;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [7:0]         wdata;
    logic               re;

    logic [7:0]         rdata_reg;
    mem_op_t            meta_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg;
    logic               out_load;
    logic               s1_free;
    logic               bit_val;

    // clearing pass: bit ADDR_W of the counter marks the sweep done
    assign clearing        = !clr_cnt_reg[ADDR_W];
    assign status.clearing = clearing;

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_free  = !s1_valid_reg || out_load;
    assign pop      = !clearing && q_status.not_empty && (!head.is_read || s1_free);

    assign we    = clearing || (pop && !head.is_read);
    assign waddr = clearing ? clr_cnt_reg[ADDR_W-1:0] : head.addr;
    assign wdata = clearing ? 8'd0 : head.wdata;
    assign re    = pop && head.is_read;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[head.addr];
            meta_reg  <= head;
        end
        if (out_load)
        begin
            out_reg.pixel_on        <= meta_reg.flash ? 1'b1 : (bit_val ^ meta_reg.invert);
            out_reg.display_enabled <= meta_reg.enable;
        end
    end

    assign bit_val = rdata_reg[meta_reg.bit_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        clr_cnt_next = clearing ? clr_cnt_reg + CLR_W'(1) : clr_cnt_reg;

        if (re)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ----- tb/sv/oled_controller_byte_interface_top_test.sv -----
`timescale 1ns / 1ps

module oled_controller_byte_interface_top_test;
    import olbi_pkg::*;

    // cmd code 3 has no meaning; the block must drop it without a result
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int unsigned WORD_TARGET = 1620;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_LIMIT = 10;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    oled_controller_byte_interface_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Shadow copy of the controller: bus mode, pending argument, write pointer,
    // address windows, display flags and the 1 KB page store.
    mode_t      bus_mode;
    arg_t       arg_state;
    logic [7:0] cur_column;
    logic [7:0] cur_page;
    logic [7:0] col_low;
    logic [7:0] col_high;
    logic [7:0] page_high;
    logic       flash_all;
    logic       invert_on;
    logic       panel_on;
    logic [7:0] page_store [STORE_BYTES];

    in_item_t    panel_words [$];      // words still to be sent
    out_item_t   expected_pixels [$];  // pixel reads not yet answered
    int unsigned words_total;
    int unsigned words_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    int unsigned in_gap_left = 0;
    int unsigned out_stall_left = 0;
    bit          in_quiet = 1'b0;
    bit          out_quiet = 1'b0;
    out_item_t   want;

    // Apply one accepted word to the shadow state; a pixel read queues the
    // displayed bit and the enable flag.
    task automatic track_panel(input in_item_t w);
        logic [8:0]  next_col;
        logic [8:0]  next_page;
        int unsigned addr;
        arg_t        pending;
        logic        lit;
        out_item_t   res;
        case (w.cmd)
            CMD_BYTE: begin
                if (bus_mode == MODE_DATA) begin
                    addr = {24'd0, cur_column} + {24'd0, cur_page} * ROW_BYTES;
                    if (addr < STORE_BYTES)
                        page_store[addr] = w.byte_value;
                    // nine bits so 255 + 1 does not fold back to 0
                    next_col  = {1'b0, cur_column} + 9'd1;
                    next_page = {1'b0, cur_page};
                    if (next_col > {1'b0, col_high}) begin
                        next_page = next_page + 9'd1;
                        next_col  = {1'b0, col_low};
                    end
                    if (next_page > {1'b0, page_high})
                        next_page = '0;
                    cur_column = next_col[7:0];
                    cur_page   = next_page[7:0];
                end else if (bus_mode == MODE_CMD) begin
                    pending   = arg_state;
                    arg_state = ARG_NONE;
                    case (pending)
                        ARG_COL_START: begin
                            arg_state  = ARG_COL_END;
                            col_low    = w.byte_value;
                            cur_column = w.byte_value;
                        end
                        ARG_COL_END: col_high = w.byte_value;
                        ARG_PAGE_START: begin
                            arg_state = ARG_PAGE_END;
                            cur_page  = w.byte_value;
                        end
                        ARG_PAGE_END: page_high = w.byte_value;
                        ARG_SKIP: ;
                        default: begin
                            // plain command: bus drops back to idle
                            bus_mode = MODE_IDLE;
                            if (w.byte_value <= OP_COL_LO_LAST)
                                cur_column = {cur_column[7:4], w.byte_value[3:0]};
                            else if (w.byte_value <= OP_COL_HI_LAST)
                                cur_column = {w.byte_value[3:0], cur_column[3:0]};
                            else if (w.byte_value >= OP_PAGE_FIRST
                                     && w.byte_value <= OP_PAGE_LAST)
                                cur_page = {5'd0, w.byte_value[2:0]};
                            else begin
                                case (w.byte_value)
                                    OP_ADDR_MODE, OP_CONTRAST, OP_MUX_RATIO, OP_DCDC,
                                    OP_OFFSET, OP_CLK_DIV, OP_COLOR, OP_PRECHARGE,
                                    OP_COM_PINS, OP_VCOMH: arg_state = ARG_SKIP;
                                    OP_COL_WIN:   arg_state = ARG_COL_START;
                                    OP_PAGE_WIN:  arg_state = ARG_PAGE_START;
                                    OP_FLASH_OFF: flash_all = 1'b0;
                                    OP_FLASH_ON:  flash_all = 1'b1;
                                    OP_INV_OFF:   invert_on = 1'b0;
                                    OP_INV_ON:    invert_on = 1'b1;
                                    OP_DISP_OFF:  panel_on  = 1'b0;
                                    OP_DISP_ON:   panel_on  = 1'b1;
                                    default: ;
                                endcase
                            end
                        end
                    endcase
                end else begin
                    if (w.byte_value == CTRL_CMD)
                        bus_mode = MODE_CMD;
                    else if (w.byte_value == CTRL_DATA)
                        bus_mode = MODE_DATA;
                end
            end
            // a pending argument survives the end of a transaction
            CMD_END: bus_mode = MODE_IDLE;
            CMD_READ: begin
                // row of 128 bytes per page, so the address is {page, x}
                addr = {22'd0, w.pixel_y[5:3], w.pixel_x};
                lit  = page_store[addr][w.pixel_y[2:0]];
                if (flash_all)
                    lit = 1'b1;
                else if (invert_on)
                    lit = ~lit;
                res.pixel_on        = lit;
                res.display_enabled = panel_on;
                expected_pixels.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [1:0] c, input logic [7:0] b,
                             input logic [6:0] x, input logic [5:0] y);
        in_item_t w;
        w.cmd        = c;
        w.byte_value = b;
        w.pixel_x    = x;
        w.pixel_y    = y;
        panel_words.push_back(w);
    endtask

    // bus byte; the pixel fields are don't-care, so they get noise
    task automatic push_byte(input logic [7:0] b);
        push_word(CMD_BYTE, b, 7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
    endtask

    // mostly back to back, sometimes a short gap, now and then a long hole
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost read ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Driver: one word per handshake; valid stays up and the word holds
    // steady while the block stalls.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                track_panel(in_item);
                words_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    in_valid <= 1'b0;
                end else if (panel_words.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item  <= panel_words.pop_front();
                    // switch between gappy and back-to-back stretches
                    if ($urandom_range(0, 63) == 0)
                        in_quiet = !in_quiet;
                    in_gap_left = in_quiet ? 0 : idle_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each delivered read against the oldest expectation and
    // throws random stalls at the output.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    log_mismatch($sformatf("unexpected pixel word on=%0b en=%0b",
                                           out_item.pixel_on, out_item.display_enabled));
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_item.pixel_on !== want.pixel_on)
                        log_mismatch($sformatf("pixel_on: expected %0b, got %0b",
                                               want.pixel_on, out_item.pixel_on));
                    if (out_item.display_enabled !== want.display_enabled)
                        log_mismatch($sformatf("display_enabled: expected %0b, got %0b",
                                               want.display_enabled,
                                               out_item.display_enabled));
                end
            end
            if (out_stall_left > 0) begin
                out_stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 63) == 0)
                    out_quiet = !out_quiet;
                out_stall_left = out_quiet ? 0 : idle_gap();
            end
        end
    end

    initial begin
        int unsigned kind;
        int unsigned sel;
        logic [7:0]  op;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  top;
        bit          in_cmd;
        bit          skip_arg;

        // power-up state of the shadow controller
        bus_mode   = MODE_IDLE;
        arg_state  = ARG_NONE;
        cur_column = '0;
        cur_page   = '0;
        col_low    = '0;
        col_high   = COL_HI_RESET;
        page_high  = PAGE_HI_RESET;
        flash_all  = 1'b0;
        invert_on  = 1'b0;
        panel_on   = 1'b0;
        foreach (page_store[i])
            page_store[i] = '0;

        // --- directed words ---
        // cleared store, panel off, at both corners
        push_word(CMD_READ, 8'h00, 7'd0, 6'd0);
        push_word(CMD_READ, 8'hff, 7'd127, 6'd63);
        // spare cmd code: no result
        push_word(CMD_SPARE, 8'hff, 7'd127, 6'd63);
        // stray byte while idle is ignored
        push_byte(8'h12);
        push_byte(CTRL_CMD);
        push_byte(OP_DISP_ON);
        // two data bytes at the origin, then read one of their bits back
        push_byte(CTRL_DATA);
        push_byte(8'hff);
        push_byte(8'h81);
        push_word(CMD_END, 8'h00, 7'd0, 6'd0);
        push_word(CMD_READ, 8'h00, 7'd1, 6'd7);
        // column window 255..255: pointer compare must not wrap at 8 bits
        push_byte(CTRL_CMD);
        push_byte(OP_COL_WIN);
        push_byte(CTRL_CMD);
        push_byte(8'hff);
        push_byte(8'hff);
        // page window opened, then the transaction ends with the argument pending
        push_byte(OP_PAGE_WIN);
        push_word(CMD_END, 8'h00, 7'd0, 6'd0);
        push_byte(CTRL_CMD);
        push_byte(8'hff);
        push_byte(8'hff);
        push_word(CMD_END, 8'h00, 7'd0, 6'd0);
        // first byte lands beyond the store and is dropped, page 255 wraps to 0;
        // second byte goes to column 255 of page 0
        push_byte(CTRL_DATA);
        push_byte(8'h5a);
        push_byte(8'ha5);
        push_word(CMD_END, 8'h00, 7'd0, 6'd0);
        // column 255 of page 0 shows up as x 127 on the second page
        push_word(CMD_READ, 8'h00, 7'd127, 6'd8);
        push_word(CMD_READ, 8'h00, 7'd127, 6'd15);

        // --- random transactions ---
        while (panel_words.size() < WORD_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 42) begin
                // data burst, sometimes long enough to wrap windows
                push_byte(CTRL_DATA);
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 12))
                    push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) != 0)
                    push_word(CMD_END, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
            end else if (kind < 74) begin
                // one transaction carrying a few commands; after an argument
                // the bus is still in command mode, so no new control byte
                in_cmd = 1'b0;
                repeat ($urandom_range(1, 3)) begin
                    skip_arg = 1'b0;
                    sel = $urandom_range(0, 19);
                    case (sel)
                        0, 1: op = 8'($urandom_range(OP_COL_LO_FIRST, OP_COL_LO_LAST));
                        2: op = 8'($urandom_range(OP_COL_HI_FIRST, OP_COL_HI_FIRST + 8'd7));
                        3: op = 8'($urandom_range(OP_COL_HI_FIRST, OP_COL_HI_LAST));
                        4, 5: op = 8'($urandom_range(OP_PAGE_FIRST, OP_PAGE_LAST));
                        6, 7, 8: op = OP_COL_WIN;
                        9, 10: op = OP_PAGE_WIN;
                        11: op = ($urandom_range(0, 3) == 0) ? OP_FLASH_ON : OP_FLASH_OFF;
                        12: op = $urandom_range(0, 1) ? OP_INV_ON : OP_INV_OFF;
                        13: op = ($urandom_range(0, 4) != 0) ? OP_DISP_ON : OP_DISP_OFF;
                        14, 15: begin
                            skip_arg = 1'b1;
                            case ($urandom_range(0, 9))
                                0: op = OP_ADDR_MODE;
                                1: op = OP_CONTRAST;
                                2: op = OP_MUX_RATIO;
                                3: op = OP_DCDC;
                                4: op = OP_OFFSET;
                                5: op = OP_CLK_DIV;
                                6: op = OP_COLOR;
                                7: op = OP_PRECHARGE;
                                8: op = OP_COM_PINS;
                                default: op = OP_VCOMH;
                            endcase
                        end
                        // any byte at all, including ones that do nothing
                        default: op = 8'($urandom_range(0, 255));
                    endcase
                    if (!in_cmd)
                        push_byte(CTRL_CMD);
                    push_byte(op);
                    in_cmd = 1'b0;
                    if (op == OP_COL_WIN || op == OP_PAGE_WIN) begin
                        push_byte(CTRL_CMD);
                        top = (op == OP_COL_WIN) ? COL_HI_RESET : PAGE_HI_RESET;
                        sel = $urandom_range(0, 9);
                        if (sel == 0) begin
                            lo = 8'($urandom_range(0, 255));
                            hi = 8'($urandom_range(0, 255));
                        end else if (sel < 3) begin
                            lo = '0;
                            hi = top;
                        end else begin
                            lo = 8'($urandom_range(0, top));
                            hi = 8'($urandom_range(lo, top));
                        end
                        push_byte(lo);
                        push_byte(hi);
                        in_cmd = 1'b1;
                    end else if (skip_arg) begin
                        push_byte(CTRL_CMD);
                        push_byte(8'($urandom_range(0, 255)));
                        in_cmd = 1'b1;
                    end
                end
                if ($urandom_range(0, 3) != 0)
                    push_word(CMD_END, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 8))
                    push_word(CMD_READ, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
            end else begin
                // noise: any code, any byte, breaks sequences mid-way
                repeat ($urandom_range(1, 4))
                    push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
            end
        end
        words_total = panel_words.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // every word taken and every read answered, then a short drain to
        // catch stray results
        while (words_accepted != words_total || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/olbi_pkg.sv
sv/olbi_front.sv
sv/olbi_queue.sv
sv/olbi_back.sv
sv/oled_controller_byte_interface_top.sv
tb/sv/oled_controller_byte_interface_top_test.sv
